@@ rtl/plr_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the positional list block
// no dependencies
package plr_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ENTRY_WIDTH_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 64;
    localparam int STS_W  = 2;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 7;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND,
        CMD_REMOVE_LAST,
        CMD_INSERT,
        CMD_REMOVE_AT,
        CMD_READ,
        CMD_CLEAR,
        CMD_SORT,
        CMD_UNUSED
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK,
        STS_FULL,
        STS_EMPTY,
        STS_BAD_INDEX
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic exec;
        logic sort_step;
        logic sort_phase;
    } t_dp_ctrl;

endpackage

@@ rtl/plr_in_if.sv @@
`timescale 1ns / 1ps
// request channel: valid/ready handshake with command payload
// depends on plr_pkg
interface plr_in_if;
    logic                        valid;
    logic                        ready;
    logic [plr_pkg::CMD_W-1:0]   command;
    logic [plr_pkg::POS_W-1:0]   position;
    logic [plr_pkg::VAL_W-1:0]   entry_value;

    modport source (output valid, output command, output position, output entry_value,
                    input ready);
    modport sink   (input valid, input command, input position, input entry_value,
                    output ready);
endinterface

@@ rtl/plr_out_if.sv @@
`timescale 1ns / 1ps
// result channel: valid/ready handshake with status payload
// depends on plr_pkg
interface plr_out_if;
    logic                        valid;
    logic                        ready;
    logic [plr_pkg::STS_W-1:0]   status;
    logic [plr_pkg::VAL_W-1:0]   read_value;
    logic [plr_pkg::CNT_W-1:0]   entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

@@ rtl/positional_list_with_sort_core.sv @@
`timescale 1ns / 1ps
// top level of the positional list with sort
// depends on plr_pkg, plr_in_if, plr_out_if, plr_ctrl, plr_datapath
//
// usage:
//   i_in carries one command request (append, remove last, insert at,
//   remove at, read at, clear, sort) on a valid/ready handshake; o_out
//   returns one result per request: status, read value, entry count.
//   the capacity register sits at APB address 0 and is to be written by the user only
//   while the block is idle; the block itself does not enforce this.
// latency and throughput:
//   every command except sort is executed in the cycle it is accepted and
//   its result is valid on the next cycle; one request per cycle while the
//   receiver takes results.
//   sort runs MAX_ENTRIES odd-even transposition steps over the cell row,
//   one step per cycle; no request is accepted until the sort has finished
//   and its result has been loaded.
// reset: the list is emptied and capacity returns to 64; cells are not cleared.
// stall: a held result blocks new requests until it is taken, except that a
//   new request is accepted in the cycle the held one leaves.
module positional_list_with_sort_core #(
    parameter int MAX_ENTRIES = plr_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_WIDTH = plr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    plr_in_if.sink                     i_in,
    plr_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [plr_pkg::APB_AW-1:0] paddr,
    input  logic [plr_pkg::APB_DW-1:0] pwdata,
    output logic [plr_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    logic [plr_pkg::CAP_W-1:0] r_capacity;
    plr_pkg::t_dp_ctrl         dp_ctrl;
    logic                      in_ready, out_valid;

    assign pready = 1'b1;
    assign prdata = (paddr == plr_pkg::ADDR_CAPACITY)
                  ? plr_pkg::APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= plr_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == plr_pkg::ADDR_CAPACITY) begin
            r_capacity <= pwdata[plr_pkg::CAP_W-1:0];
        end
    end

    plr_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_dp_ctrl   (dp_ctrl)
    );

    plr_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .ENTRY_WIDTH(ENTRY_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_ctrl     (dp_ctrl),
        .i_capacity    (r_capacity),
        .i_command     (i_in.command),
        .i_position    (i_in.position),
        .i_entry_value (i_in.entry_value),
        .o_status      (o_out.status),
        .o_read_value  (o_out.read_value),
        .o_entry_count (o_out.entry_count)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule

@@ rtl/plr_ctrl.sv @@
`timescale 1ns / 1ps
// controller: handshakes, sort pass sequencing, result register valid
// depends on plr_pkg
module plr_ctrl #(
    parameter int MAX_ENTRIES = plr_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [plr_pkg::CMD_W-1:0] i_command,
    output logic                      o_in_ready,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output plr_pkg::t_dp_ctrl         o_dp_ctrl
);
    localparam int PW = $clog2(MAX_ENTRIES);
    localparam logic [PW-1:0] LAST_PHASE = PW'(MAX_ENTRIES - 1);

    plr_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_phase, n_phase;
    logic            r_out_valid, n_out_valid;
    logic            out_free, accept, is_sort, load_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign is_sort  = plr_pkg::t_cmd'(i_command) == plr_pkg::CMD_SORT;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plr_pkg::ST_IDLE: begin
                if (accept && is_sort) n_state = plr_pkg::ST_SORT;
            end
            plr_pkg::ST_SORT: begin
                if (r_phase == LAST_PHASE) n_state = plr_pkg::ST_DONE;
            end
            plr_pkg::ST_DONE: begin
                if (out_free) n_state = plr_pkg::ST_IDLE;
            end
            default: n_state = plr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready           = (r_state == plr_pkg::ST_IDLE) && out_free;
        o_dp_ctrl.exec       = i_in_valid && (r_state == plr_pkg::ST_IDLE) && out_free;
        o_dp_ctrl.sort_step  = r_state == plr_pkg::ST_SORT;
        o_dp_ctrl.sort_phase = r_phase[0];
        load_out = ((r_state == plr_pkg::ST_IDLE) && accept && !is_sort)
                 || ((r_state == plr_pkg::ST_DONE) && out_free);
        n_out_valid = (r_out_valid && !i_out_ready) || load_out;
        n_phase     = (r_state == plr_pkg::ST_SORT) ? r_phase + 1'b1 : '0;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plr_pkg::ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

@@ rtl/plr_datapath.sv @@
`timescale 1ns / 1ps
// datapath: row of shifting entry cells, fill count, result register
// depends on plr_pkg
module plr_datapath #(
    parameter int MAX_ENTRIES = plr_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_WIDTH = plr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  plr_pkg::t_dp_ctrl         i_dp_ctrl,
    input  logic [plr_pkg::CAP_W-1:0] i_capacity,
    input  logic [plr_pkg::CMD_W-1:0] i_command,
    input  logic [plr_pkg::POS_W-1:0] i_position,
    input  logic [plr_pkg::VAL_W-1:0] i_entry_value,
    output logic [plr_pkg::STS_W-1:0] o_status,
    output logic [plr_pkg::VAL_W-1:0] o_read_value,
    output logic [plr_pkg::CNT_W-1:0] o_entry_count
);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int W  = (CW > plr_pkg::POS_W) ? CW : plr_pkg::POS_W;
    localparam logic [W-1:0] MAX_W = W'(MAX_ENTRIES);

    logic [ENTRY_WIDTH-1:0]   r_cell [MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0]   n_cell [MAX_ENTRIES];
    logic [CW-1:0]            r_fill, n_fill;
    logic [plr_pkg::STS_W-1:0] r_status, n_status;
    logic [plr_pkg::VAL_W-1:0] r_rd, n_rd;

    logic [W-1:0] fill_w, pos_w, cap_w, lim_w, idx_w;
    logic         full, do_ins, do_del;
    logic [ENTRY_WIDTH-1:0] val;

    assign fill_w = W'(r_fill);
    assign pos_w  = W'(i_position);
    assign cap_w  = W'(i_capacity);
    assign lim_w  = (cap_w < MAX_W) ? cap_w : MAX_W;
    assign full   = fill_w >= lim_w;
    assign val    = i_entry_value[ENTRY_WIDTH-1:0];

    always_comb begin
        n_status = plr_pkg::STS_OK;
        n_rd     = '0;
        n_fill   = r_fill;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        idx_w    = pos_w;
        unique case (plr_pkg::t_cmd'(i_command))
            plr_pkg::CMD_APPEND: begin
                idx_w = fill_w;
                if (full) n_status = plr_pkg::STS_FULL;
                else do_ins = 1'b1;
            end
            plr_pkg::CMD_REMOVE_LAST: begin
                if (r_fill == '0) n_status = plr_pkg::STS_EMPTY;
                else n_fill = r_fill - 1'b1;
            end
            plr_pkg::CMD_INSERT: begin
                if (full) n_status = plr_pkg::STS_FULL;
                else if (pos_w > fill_w) n_status = plr_pkg::STS_BAD_INDEX;
                else do_ins = 1'b1;
            end
            plr_pkg::CMD_REMOVE_AT: begin
                if (pos_w >= fill_w) n_status = plr_pkg::STS_BAD_INDEX;
                else begin
                    do_del = 1'b1;
                    n_fill = r_fill - 1'b1;
                end
            end
            plr_pkg::CMD_READ: begin
                if (r_fill == '0) n_status = plr_pkg::STS_EMPTY;
                else if (pos_w >= fill_w) n_status = plr_pkg::STS_BAD_INDEX;
                else n_rd = plr_pkg::VAL_W'(r_cell[IW'(pos_w)]);
            end
            plr_pkg::CMD_CLEAR:  n_fill = '0;
            plr_pkg::CMD_SORT:   ;
            plr_pkg::CMD_UNUSED: ;
            default: ;
        endcase
        if (do_ins) n_fill = r_fill + 1'b1;
    end

    // cell i only looks at its neighbors and the shared insert value
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) n_cell[i] = r_cell[i];
        if (i_dp_ctrl.exec) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (do_ins) begin
                    if (W'(i) == idx_w) n_cell[i] = val;
                    else if (i > 0 && W'(i) > idx_w) n_cell[i] = r_cell[i-1];
                end else if (do_del) begin
                    if (i < MAX_ENTRIES - 1 && W'(i) >= idx_w) n_cell[i] = r_cell[i+1];
                end
            end
        end else if (i_dp_ctrl.sort_step) begin
            // odd-even transposition: pairs (i, i+1) with i matching phase parity
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                if ((i % 2) == int'(i_dp_ctrl.sort_phase) && W'(i + 1) < fill_w
                    && r_cell[i] > r_cell[i+1]) begin
                    n_cell[i]   = r_cell[i+1];
                    n_cell[i+1] = r_cell[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) r_cell[i] <= n_cell[i];
        if (i_dp_ctrl.exec) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_dp_ctrl.exec) begin
            r_fill <= n_fill;
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_entry_count = plr_pkg::CNT_W'(r_fill);
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for positional_list_with_sort_core
// depends on plr_pkg, plr_in_if, plr_out_if and the core
module tb;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        plr_pkg::t_status          status;
        logic [plr_pkg::VAL_W-1:0] read_value;
        logic [plr_pkg::CNT_W-1:0] entry_count;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [plr_pkg::APB_AW-1:0] paddr;
    logic [plr_pkg::APB_DW-1:0] pwdata;
    logic [plr_pkg::APB_DW-1:0] prdata;
    logic pready;

    plr_in_if  req_if ();
    plr_out_if res_if ();

    positional_list_with_sort_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [plr_pkg::VAL_W-1:0] list_cells [DEPTH];
    int unsigned      list_fill;
    int unsigned      list_cap;

    t_result pending_results [$];
    int      error_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cycles;
    longint  cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic t_result predict_list_op(plr_pkg::t_cmd cmd,
                                                logic [plr_pkg::POS_W-1:0] pos,
                                                logic [plr_pkg::VAL_W-1:0] val);
        t_result r;
        int unsigned lim;
        int unsigned p;
        logic [plr_pkg::VAL_W-1:0] key;
        int j;
        r.status = plr_pkg::STS_OK;
        r.read_value = '0;
        lim = (list_cap < DEPTH) ? list_cap : DEPTH;
        p = pos;
        case (cmd)
            plr_pkg::CMD_APPEND: begin
                if (list_fill >= lim) r.status = plr_pkg::STS_FULL;
                else begin
                    list_cells[list_fill] = val;
                    list_fill++;
                end
            end
            plr_pkg::CMD_REMOVE_LAST: begin
                if (list_fill == 0) r.status = plr_pkg::STS_EMPTY;
                else list_fill--;
            end
            plr_pkg::CMD_INSERT: begin
                if (list_fill >= lim) r.status = plr_pkg::STS_FULL;
                else if (p > list_fill) r.status = plr_pkg::STS_BAD_INDEX;
                else begin
                    for (int i = list_fill; i > p; i--) list_cells[i] = list_cells[i-1];
                    list_cells[p] = val;
                    list_fill++;
                end
            end
            plr_pkg::CMD_REMOVE_AT: begin
                if (p >= list_fill) r.status = plr_pkg::STS_BAD_INDEX;
                else begin
                    for (int i = p; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
                    list_fill--;
                end
            end
            plr_pkg::CMD_READ: begin
                if (list_fill == 0) r.status = plr_pkg::STS_EMPTY;
                else if (p >= list_fill) r.status = plr_pkg::STS_BAD_INDEX;
                else r.read_value = list_cells[p];
            end
            plr_pkg::CMD_CLEAR: list_fill = 0;
            plr_pkg::CMD_SORT: begin
                for (int i = 1; i < list_fill; i++) begin
                    key = list_cells[i];
                    j = i;
                    while (j > 0 && list_cells[j-1] > key) begin
                        list_cells[j] = list_cells[j-1];
                        j--;
                    end
                    list_cells[j] = key;
                end
            end
            default: ;
        endcase
        r.entry_count = list_fill[plr_pkg::CNT_W-1:0];
        return r;
    endfunction

    // valid stays up after an accepted request unless the sender goes idle
    task automatic send_request(plr_pkg::t_cmd cmd, logic [plr_pkg::POS_W-1:0] pos,
                                logic [plr_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.position    <= pos;
        req_if.entry_value <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(predict_list_op(cmd, pos, val));
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t unexpected result status=%0d count=%0d", $time,
                     res_if.status, res_if.entry_count);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (res_if.status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status, res_if.status);
            error_count++;
        end
        if (res_if.read_value !== want.read_value) begin
            $display("%0t read_value expected %h actual %h", $time, want.read_value,
                     res_if.read_value);
            error_count++;
        end
        if (res_if.entry_count !== want.entry_count) begin
            $display("%0t entry_count expected %0d actual %0d", $time, want.entry_count,
                     res_if.entry_count);
            error_count++;
        end
    endtask

    // receiver side
    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) check_result();
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_capacity(int unsigned cap);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= plr_pkg::ADDR_CAPACITY;
        pwdata  <= cap;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        list_cap = cap & 7'h7f;
    endtask

    function automatic logic [plr_pkg::VAL_W-1:0] rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {32'h0, $urandom} % 8;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        send_request(plr_pkg::CMD_REMOVE_LAST, 0, 0);
        send_request(plr_pkg::CMD_READ, 0, 0);
        send_request(plr_pkg::CMD_REMOVE_AT, 0, 0);
        send_request(plr_pkg::CMD_SORT, 0, 0);
        send_request(plr_pkg::CMD_APPEND, 0, '1);
        send_request(plr_pkg::CMD_SORT, 0, 0);
        send_request(plr_pkg::CMD_APPEND, 0, '0);
        send_request(plr_pkg::CMD_INSERT, 3, 64'h5);
        send_request(plr_pkg::CMD_INSERT, 0, 64'h8000_0000_0000_0000);
        send_request(plr_pkg::CMD_INSERT, 3, 64'h5);
        send_request(plr_pkg::CMD_INSERT, 7'h7f, 64'h5);
        send_request(plr_pkg::CMD_READ, 4, 0);
        send_request(plr_pkg::CMD_READ, 7'h7f, 0);
        send_request(plr_pkg::CMD_SORT, 0, 0);
        send_request(plr_pkg::CMD_READ, 0, 0);
        send_request(plr_pkg::CMD_READ, 3, 0);
        send_request(plr_pkg::CMD_REMOVE_AT, 1, 0);
        send_request(plr_pkg::CMD_REMOVE_AT, 3, 0);
        send_request(plr_pkg::CMD_UNUSED, 7'h7f, '1);
        send_request(plr_pkg::CMD_CLEAR, 0, 0);
        send_request(plr_pkg::CMD_READ, 0, 0);
    endtask

    task automatic test_capacity_limits();
        write_capacity(2);
        for (int i = 0; i < 4; i++) send_request(plr_pkg::CMD_APPEND, 0, rand_word());
        send_request(plr_pkg::CMD_INSERT, 0, 64'h1);
        // lowered below the fill, entries kept
        write_capacity(1);
        send_request(plr_pkg::CMD_APPEND, 0, 64'h2);
        send_request(plr_pkg::CMD_READ, 1, 0);
        write_capacity(0);
        send_request(plr_pkg::CMD_CLEAR, 0, 0);
        send_request(plr_pkg::CMD_APPEND, 0, 64'h3);
        send_request(plr_pkg::CMD_INSERT, 0, 64'h3);
        write_capacity(7'h7f);
        for (int i = 0; i < 66; i++) send_request(plr_pkg::CMD_APPEND, 0, rand_word());
        send_request(plr_pkg::CMD_SORT, 0, 0);
        for (int i = 0; i < 64; i++) send_request(plr_pkg::CMD_READ, plr_pkg::POS_W'(i), 0);
    endtask

    task automatic run_random(int n);
        plr_pkg::t_cmd cmd;
        int k;
        logic [plr_pkg::POS_W-1:0] pos;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 30) cmd = plr_pkg::CMD_APPEND;
            else if (k < 45) cmd = plr_pkg::CMD_INSERT;
            else if (k < 55) cmd = plr_pkg::CMD_REMOVE_AT;
            else if (k < 62) cmd = plr_pkg::CMD_REMOVE_LAST;
            else if (k < 88) cmd = plr_pkg::CMD_READ;
            else if (k < 92) cmd = plr_pkg::CMD_CLEAR;
            else if (k < 97) cmd = plr_pkg::CMD_SORT;
            else cmd = plr_pkg::CMD_UNUSED;
            if ($urandom_range(9) == 0) pos = plr_pkg::POS_W'($urandom);
            else pos = plr_pkg::POS_W'($urandom_range(list_fill));
            send_request(cmd, pos, rand_word());
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(350);
        write_capacity($urandom_range(1, 20));
        send_idle_pct = 45; recv_stall_pct = 0;
        run_random(350);
        write_capacity(64);
        send_idle_pct = 0;  recv_stall_pct = 45;
        run_random(350);
        write_capacity($urandom_range(30, 64));
        send_idle_pct = 35; recv_stall_pct = 35;
        run_random(350);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 300;
        run_random(100);
    endtask

    initial begin
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        list_fill = 0;
        list_cap = plr_pkg::CAP_RESET;
        for (int i = 0; i < DEPTH; i++) list_cells[i] = '0;
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        req_if.valid <= 1'b0;
        req_if.command <= plr_pkg::CMD_APPEND;
        req_if.position <= '0;
        req_if.entry_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity_limits();
        write_capacity(64);
        test_random_phases();
        test_backpressure();
        wait_drained();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ positional_list_with_sort_core.f @@
rtl/plr_pkg.sv
rtl/plr_in_if.sv
rtl/plr_out_if.sv
rtl/plr_ctrl.sv
rtl/plr_datapath.sv
rtl/positional_list_with_sort_core.sv
verif/tb.sv
